// ----- rtl/core/tsvf_pkg.sv -----
// types, constants and arithmetic helpers of the state variable filter
package tsvf_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 24;
   localparam int CH_W         = 3;
   localparam int CH_ADDR_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam int ST_W    = 32;
   localparam int G_W     = 28;
   localparam int R2_W    = 26;
   localparam int NORM_W  = 25;
   localparam int MODE_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 28;

   localparam int COEF_FRAC = 24;
   localparam int OPA_W     = 38;
   localparam int OPB_U_W   = G_W + 1;
   localparam int OPB_W     = OPB_U_W + 1;
   localparam int PROD_W    = OPA_W + OPB_W;
   localparam int RND_W     = PROD_W - COEF_FRAC;
   localparam int ACC_W     = RND_W + 1;

   localparam logic [R2_W-1:0]   R2_RESET   = R2_W'(33554432);
   localparam logic [NORM_W-1:0] NORM_RESET = NORM_W'(16777216);

   typedef enum logic [MODE_W-1:0] {
      MODE_LP2   = 4'd0,
      MODE_LP1   = 4'd1,
      MODE_LP2N  = 4'd2,
      MODE_HP2   = 4'd3,
      MODE_HP1   = 4'd4,
      MODE_HP2N  = 4'd5,
      MODE_BP2   = 4'd6,
      MODE_BP2N  = 4'd7,
      MODE_AP2   = 4'd8,
      MODE_PEAK  = 4'd9,
      MODE_NOTCH = 4'd10
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE = 2'd0,
      CSR_G    = 2'd1,
      CSR_R2   = 2'd2,
      CSR_NORM = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL1,
      ST_DIFF,
      ST_MUL2,
      ST_HP,
      ST_MUL3,
      ST_BP,
      ST_MUL4,
      ST_LP,
      ST_MUL5,
      ST_OUT
   } fsm_state_type;

   typedef enum logic {
      ACT_PROCESS = 1'b0,
      ACT_CLEAR   = 1'b1
   } action_type;

   typedef struct packed {
      logic                          action;
      logic [CH_W-1:0]               channel;
      logic signed [SAMPLE_BITS-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]               channel_out;
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
   } rsp_type;

   typedef struct packed {
      logic                   clip;
      logic signed [ST_W-1:0] val;
   } sat_st_type;

   typedef struct packed {
      logic                          clip;
      logic signed [SAMPLE_BITS-1:0] val;
   } sat_out_type;

   // round to nearest, ties up, after dropping the coefficient fraction
   function automatic logic signed [RND_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] sum;
      sum = p + PROD_W'(1 << (COEF_FRAC - 1));
      return sum[PROD_W-1:COEF_FRAC];
   endfunction

   function automatic sat_st_type sat_st(input logic signed [ACC_W-1:0] v);
      sat_st_type r;
      if ((&v[ACC_W-1:ST_W-1]) || !(|v[ACC_W-1:ST_W-1])) begin
         r.clip = 1'b0;
         r.val  = v[ST_W-1:0];
      end else begin
         r.clip = 1'b1;
         r.val  = v[ACC_W-1] ? {1'b1, {(ST_W-1){1'b0}}} : {1'b0, {(ST_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic sat_out_type sat_out(input logic signed [ACC_W-1:0] v);
      sat_out_type r;
      if ((&v[ACC_W-1:SAMPLE_BITS-1]) || !(|v[ACC_W-1:SAMPLE_BITS-1])) begin
         r.clip = 1'b0;
         r.val  = v[SAMPLE_BITS-1:0];
      end else begin
         r.clip = 1'b1;
         r.val  = v[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                             : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/tsvf_ram.sv -----
// generic single-port-write ram with registered read
module tsvf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/tpt_state_variable_filter.sv -----
// top level of the multichannel trapezoidal state variable filter
// After its accept a processed sample takes ST_READ for the state memory read, then five
// coefficient products on one shared multiplier, each a product register (ST_MULn) and
// then rounding and the adds that follow; the rounding step of the last product (ST_OUT)
// also forms and saturates the output. A clear beat, or a channel out of range, goes from
// ST_IDLE straight to ST_OUT. ST_OUT loads the output register only while it holds no
// stalled result. The next beat is accepted in the cycle after the result is loaded, so no
// new beat is taken before the last one's result is in the output register.
// Both integrator states of a channel sit in one memory word; per-channel valid bits make a
// cleared channel read as zero, so reset, clear beats and a filter_mode change need no
// clearing pass.
module tpt_state_variable_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tsvf_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tsvf_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_we,
   input  logic [tsvf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsvf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tsvf_pkg::*;

   localparam logic [CH_W:0] NUM_CH_EXT = (CH_W + 1)'(NUM_CHANNELS);

   fsm_state_type state_ff, state_in;

   mode_type            mode_ff;
   logic [G_W-1:0]      g_ff;
   logic [R2_W-1:0]     r2_ff;
   logic [NORM_W-1:0]   norm_ff;

   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;

   logic [CH_W-1:0]               ch_ff, ch_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                          bypass_ff, bypass_in;
   logic signed [ST_W-1:0]        s1_ff, s1_in, s2_ff, s2_in;
   logic signed [ST_W-1:0]        hp_ff, hp_in, bp_ff, bp_in, lp_ff, lp_in;
   logic                          clip_ff, clip_in;
   logic signed [OPA_W-1:0]       op_a_ff, op_a_in;
   logic [OPB_U_W-1:0]            op_b_ff, op_b_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                    ram_we;
   logic [2*ST_W-1:0]       ram_wdata, ram_rdata;

   logic                    req_accept;
   logic                    ch_oor;
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-1:0] y;
   sat_st_type              sat_a, sat_b;
   sat_out_type             sat_y;
   logic signed [ST_W-1:0]  ram_s1, ram_s2;

   tsvf_ram #(
      .WIDTH (2 * ST_W),
      .DEPTH (NUM_CHANNELS)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ch_ff[CH_ADDR_W-1:0]),
      .wdata (ram_wdata),
      .raddr (req_payload.channel[CH_ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign ch_oor     = ({1'b0, req_payload.channel} >= NUM_CH_EXT);
   assign rnd        = ACC_W'(round_prod(prod_ff));
   assign prod_in    = op_a_ff * $signed({1'b0, op_b_ff});
   assign ram_s1     = valid_ff[ch_ff[CH_ADDR_W-1:0]] ? ram_rdata[2*ST_W-1:ST_W] : '0;
   assign ram_s2     = valid_ff[ch_ff[CH_ADDR_W-1:0]] ? ram_rdata[ST_W-1:0] : '0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LP2;
         g_ff    <= '0;
         r2_ff   <= R2_RESET;
         norm_ff <= NORM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE: mode_ff <= mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_G:    g_ff    <= csr_wdata[G_W-1:0];
            CSR_R2:   r2_ff   <= csr_wdata[R2_W-1:0];
            CSR_NORM: norm_ff <= csr_wdata[NORM_W-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff     <= ch_in;
      x_ff      <= x_in;
      bypass_ff <= bypass_in;
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      hp_ff     <= hp_in;
      bp_ff     <= bp_in;
      lp_ff     <= lp_in;
      clip_ff   <= clip_in;
      op_a_ff   <= op_a_in;
      op_b_ff   <= op_b_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      ch_in        = ch_ff;
      x_in         = x_ff;
      bypass_in    = bypass_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      hp_in        = hp_ff;
      bp_in        = bp_ff;
      lp_in        = lp_ff;
      clip_in      = clip_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_wdata    = {s1_ff, s2_ff};
      sat_a        = sat_st(rnd);
      sat_b        = sat_st(rnd);
      y            = '0;
      sat_y        = sat_out(y);

      // filter_mode change drops every channel's state
      if (csr_we && (csr_index == CSR_MODE) && (csr_wdata[MODE_W-1:0] != mode_ff)) begin
         valid_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ch_in     = req_payload.channel;
               x_in      = req_payload.sample_in;
               bypass_in = ch_oor || (req_payload.action == ACT_CLEAR);
               clip_in   = 1'b0;
               if (ch_oor) begin
                  state_in = ST_OUT;
               end else if (req_payload.action == ACT_CLEAR) begin
                  valid_in[req_payload.channel[CH_ADDR_W-1:0]] = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            s1_in    = ram_s1;
            s2_in    = ram_s2;
            op_a_in  = OPA_W'(ram_s1);
            op_b_in  = OPB_U_W'(g_ff) + OPB_U_W'(r2_ff);
            state_in = ST_MUL1;
         end
         ST_MUL1: state_in = ST_DIFF;
         ST_DIFF: begin
            y        = ACC_W'(x_ff) - rnd - ACC_W'(s2_ff);
            op_a_in  = y[OPA_W-1:0];
            op_b_in  = OPB_U_W'(norm_ff);
            state_in = ST_MUL2;
         end
         ST_MUL2: state_in = ST_HP;
         ST_HP: begin
            sat_a    = sat_st(rnd);
            hp_in    = sat_a.val;
            clip_in  = clip_ff | sat_a.clip;
            op_a_in  = OPA_W'(sat_a.val);
            op_b_in  = OPB_U_W'(g_ff);
            state_in = ST_MUL3;
         end
         ST_MUL3: state_in = ST_BP;
         ST_BP: begin
            sat_a    = sat_st(rnd + ACC_W'(s1_ff));
            sat_b    = sat_st(rnd + ACC_W'(sat_a.val));
            bp_in    = sat_a.val;
            s1_in    = sat_b.val;
            clip_in  = clip_ff | sat_a.clip | sat_b.clip;
            op_a_in  = OPA_W'(sat_a.val);
            op_b_in  = OPB_U_W'(g_ff);
            state_in = ST_MUL4;
         end
         ST_MUL4: state_in = ST_LP;
         ST_LP: begin
            sat_a     = sat_st(rnd + ACC_W'(s2_ff));
            sat_b     = sat_st(rnd + ACC_W'(sat_a.val));
            lp_in     = sat_a.val;
            s2_in     = sat_b.val;
            clip_in   = clip_ff | sat_a.clip | sat_b.clip;
            ram_we    = 1'b1;
            ram_wdata = {s1_ff, sat_b.val};
            valid_in[ch_ff[CH_ADDR_W-1:0]] = 1'b1;
            case (mode_ff)
               MODE_HP2N:           op_a_in = OPA_W'(hp_ff);
               MODE_BP2N, MODE_AP2: op_a_in = OPA_W'(bp_ff);
               default:             op_a_in = OPA_W'(sat_a.val);
            endcase
            op_b_in  = OPB_U_W'(r2_ff);
            state_in = ST_MUL5;
         end
         ST_MUL5: state_in = ST_OUT;
         ST_OUT: begin
            case (mode_ff)
               MODE_LP1:   y = ACC_W'(lp_ff) + ACC_W'(bp_ff);
               MODE_LP2N:  y = rnd;
               MODE_HP2:   y = ACC_W'(hp_ff);
               MODE_HP1:   y = ACC_W'(hp_ff) + ACC_W'(bp_ff);
               MODE_HP2N:  y = rnd;
               MODE_BP2:   y = ACC_W'(bp_ff);
               MODE_BP2N:  y = rnd;
               MODE_AP2:   y = ACC_W'(x_ff) - (rnd <<< 1);
               MODE_PEAK:  y = ACC_W'(lp_ff) + ACC_W'(hp_ff);
               MODE_NOTCH: y = ACC_W'(lp_ff) - ACC_W'(hp_ff);
               default:    y = ACC_W'(lp_ff);
            endcase
            sat_y = sat_out(y);
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.channel_out = ch_ff;
               rsp_in.sample_out  = bypass_ff ? '0 : sat_y.val;
               rsp_in.clipped     = bypass_ff ? 1'b0 : (clip_ff | sat_y.clip);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
